// ----- hdl/bitmap_contiguous_sector_allocator_defines.svh -----
// Assertion macros for the bitmap contiguous sector allocator checker.
// No dependencies; the including module must have clk_i and rst_ni in scope.
`ifndef BITMAP_CONTIGUOUS_SECTOR_ALLOCATOR_DEFINES_SVH
`define BITMAP_CONTIGUOUS_SECTOR_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BCSA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bcsa check failed");

// Next-cycle implication, disabled during reset.
`define BCSA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bcsa check failed");

`endif

// ----- hdl/bcsa_pkg.sv -----
// Shared types and constants for the bitmap contiguous sector allocator.
// No dependencies.
package bcsa_pkg;

  localparam int KIND_W     = 2;
  localparam int SECTOR_W   = 16;
  localparam int LENGTH_W   = 17;
  localparam int USED_W     = 17;
  localparam int STATUS_W   = 2;
  localparam int RESERVED_W = 17;

  localparam logic [RESERVED_W-1:0] RESERVED_RESET = 17'd128;
  localparam logic [USED_W-1:0]     USED_LIMIT     = 17'h1FFFF;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_MARK    = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_NO_RUN = 2'd1,
    STATUS_RANGE  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ALLOC_RD,
    ST_ALLOC_CHK,
    ST_ALLOC_BIT,
    ST_RANGE_RD,
    ST_RANGE_WR,
    ST_COUNT_RD,
    ST_COUNT_ACC,
    ST_DONE
  } state_e;

endpackage

// ----- hdl/bcsa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bcsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- hdl/bitmap_contiguous_sector_allocator.sv -----
// Top level: first-fit contiguous sector allocator over a one-bit-per-sector map.
// Depends on bcsa_pkg and bcsa_ram.
// Flow: allocate reads and checks each word scanned (bit by bit in a partly used word),
//   then a claimed run, release or mark reads and rewrites each word of its range, then a
//   used-count sweep reads every word; the result waits while an earlier one sits stalled.
// A new request is taken only back in ST_IDLE. Reset: map cleared word by word.
module bitmap_contiguous_sector_allocator
  import bcsa_pkg::*;
#(
  parameter int NUM_SECTORS = 65536,
  parameter int WORD_BITS   = 32    // power of two
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  reserved_we_i,
  input  logic [RESERVED_W-1:0] reserved_sectors_i,
  // request channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [KIND_W-1:0]     kind_i,
  input  logic [SECTOR_W-1:0]   first_sector_i,
  input  logic [LENGTH_W-1:0]   length_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [STATUS_W-1:0]   status_o,
  output logic [SECTOR_W-1:0]   start_sector_o,
  output logic [USED_W-1:0]     used_sectors_o
);

  // Geometry of the map
  localparam int WB         = $clog2(WORD_BITS);
  localparam int WORD_COUNT = (NUM_SECTORS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW         = $clog2(WORD_COUNT);
  localparam int SW         = $clog2(NUM_SECTORS + 1);
  localparam int LW         = (SW > LENGTH_W) ? SW : LENGTH_W;
  localparam int EW         = LW + 1;
  localparam int HW         = SW - WB;
  localparam int LAST_BITS  = NUM_SECTORS - (WORD_COUNT - 1) * WORD_BITS;

  localparam logic [AW-1:0]        LAST_WORD = AW'(WORD_COUNT - 1);
  localparam logic [SW-1:0]        NUM_S     = SW'(NUM_SECTORS);
  localparam logic [WB:0]          LAST_TOP  = (WB + 1)'(LAST_BITS);
  localparam logic [WB:0]          FULL_TOP  = (WB + 1)'(WORD_BITS);
  localparam logic [WORD_BITS-1:0] ONES      = '1;

  state_e                state_q, state_d;
  logic [RESERVED_W-1:0] reserved_q;
  logic [AW-1:0]         wi_q, wi_d;         // word under work
  logic [WB:0]           bi_q, bi_d;         // bit under work within the word
  logic [LW-1:0]         run_q, run_d;       // current free run length
  logic [SW-1:0]         run_start_q, run_start_d;
  logic [LW-1:0]         len_q, len_d;
  logic [SW-1:0]         ra_q, ra_d;         // first sector of range
  logic [SW-1:0]         rem1_q, rem1_d;     // last sector of range
  logic                  set_q, set_d;
  logic [WORD_BITS-1:0]  wd_q, wd_d;         // held word for the bit-serial step
  logic [SW-1:0]         cnt_q, cnt_d;
  status_e               status_q, status_d;
  logic [SECTOR_W-1:0]   start_q, start_d;

  logic                  out_valid_q, out_valid_d;
  status_e               out_status_q, out_status_d;
  logic [SECTOR_W-1:0]   out_start_q, out_start_d;
  logic [USED_W-1:0]     out_used_q, out_used_d;

  // RAM port
  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0]  ram_wdata, ram_rdata;

  // Datapath shared by the sequencer states
  logic [LW-1:0]         lo_l;
  logic [SW-1:0]         lo;
  logic [HW-1:0]         lo_word;
  logic [HW-1:0]         wi_h;
  logic [WB:0]           top;
  logic [WORD_BITS-1:0]  scan_mask, range_mask, count_mask;
  logic [WORD_BITS-1:0]  lo_part, hi_part;
  logic [WORD_BITS-1:0]  scan_bits;
  logic [WB:0]           nbits;
  logic [SW-1:0]         here_sec;
  logic [SW-1:0]         found_start, found_rem1;
  logic [EW-1:0]         rq_end, rq_first, rq_lo, rq_a;
  logic                  accept;
  logic [LW-1:0]         run_inc;

  bcsa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORD_COUNT)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Effective reserved bound, clamped to the store
  assign lo_l    = (LW'(reserved_q) > LW'(NUM_SECTORS)) ? LW'(NUM_SECTORS) : LW'(reserved_q);
  assign lo      = lo_l[SW-1:0];
  assign lo_word = lo[SW-1:WB];
  assign wi_h    = HW'(wi_q);

  // Bits of the current word, from the bit under work upward, that lie inside the store
  assign top       = (wi_q == LAST_WORD) ? LAST_TOP : FULL_TOP;
  assign scan_mask = (ONES << bi_q[WB-1:0]) & ~(ONES << top);
  assign scan_bits = ram_rdata & scan_mask;
  assign nbits     = top - bi_q;
  assign here_sec  = (SW'(wi_q) << WB) + SW'(bi_q);
  assign run_inc   = run_q + LW'(nbits);

  // A run found here starts at the current bit unless one is already open
  assign found_start = (run_q == '0) ? here_sec : run_start_q;
  assign found_rem1  = found_start + SW'(len_q) - SW'(1);

  // Range edges for release/mark
  assign lo_part    = (wi_h == ra_q[SW-1:WB]) ? (ONES << ra_q[WB-1:0]) : ONES;
  assign hi_part    = (wi_h == rem1_q[SW-1:WB]) ?
                      ~(ONES << ({1'b0, rem1_q[WB-1:0]} + (WB + 1)'(1))) : ONES;
  assign range_mask = lo_part & hi_part;

  // Count only sectors at or above the reserved bound and inside the store
  always_comb begin
    if (wi_h > lo_word) begin
      count_mask = ONES;
    end else if (wi_h == lo_word) begin
      count_mask = ONES << lo[WB-1:0];
    end else begin
      count_mask = '0;
    end
    count_mask = count_mask & ~(ONES << top);
  end

  // Request decode
  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign rq_first = EW'(first_sector_i);
  assign rq_end   = rq_first + EW'(length_i);
  assign rq_lo    = EW'(lo);
  assign rq_a     = (rq_first < rq_lo) ? rq_lo : rq_first;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d     = state_q;
    wi_d        = wi_q;
    bi_d        = bi_q;
    run_d       = run_q;
    run_start_d = run_start_q;
    len_d       = len_q;
    ra_d        = ra_q;
    rem1_d      = rem1_q;
    set_d       = set_q;
    wd_d        = wd_q;
    cnt_d       = cnt_q;
    status_d    = status_q;
    start_d     = start_q;
    ram_we      = 1'b0;
    ram_waddr   = wi_q;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = wi_q;

    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_start_d  = out_start_q;
    out_used_d   = out_used_q;

    case (state_q)
      ST_CLEAR: begin
        // Sweep zeros through the map after reset
        ram_we = 1'b1;
        if (wi_q == LAST_WORD) begin
          state_d = ST_IDLE;
        end else begin
          wi_d = wi_q + AW'(1);
        end
      end

      ST_IDLE: begin
        if (accept) begin
          status_d = STATUS_OK;
          start_d  = '0;
          wi_d     = '0;
          cnt_d    = lo;
          state_d  = ST_COUNT_RD;
          case (kind_i)
            KIND_ALLOC: begin
              if (length_i == '0) begin
                state_d = ST_COUNT_RD;
              end else if (lo == NUM_S) begin
                status_d = STATUS_NO_RUN;
              end else begin
                wi_d    = AW'(lo >> WB);
                bi_d    = {1'b0, lo[WB-1:0]};
                run_d   = '0;
                len_d   = LW'(length_i);
                state_d = ST_ALLOC_RD;
              end
            end
            KIND_RELEASE, KIND_MARK: begin
              if (rq_end > EW'(NUM_SECTORS)) begin
                status_d = STATUS_RANGE;
              end else if (rq_a < rq_end) begin
                ra_d    = rq_a[SW-1:0];
                rem1_d  = SW'(rq_end - EW'(1));
                wi_d    = AW'(rq_a[SW-1:0] >> WB);
                set_d   = (kind_i == KIND_MARK);
                state_d = ST_RANGE_RD;
              end
            end
            default: begin
              // unused kind: no change, plain count
            end
          endcase
        end
      end

      ST_ALLOC_RD: begin
        ram_re  = 1'b1;
        state_d = ST_ALLOC_CHK;
      end

      ST_ALLOC_CHK: begin
        if (scan_bits == '0) begin
          // whole remaining word free: extend run, or finish inside this word
          if (run_inc >= len_q) begin
            ra_d    = found_start;
            rem1_d  = found_rem1;
            wi_d    = AW'(found_start >> WB);
            set_d   = 1'b1;
            start_d = SECTOR_W'(found_start);
            state_d = ST_RANGE_RD;
          end else begin
            run_d = run_inc;
            if (run_q == '0) begin
              run_start_d = here_sec;
            end
            if (wi_q == LAST_WORD) begin
              status_d = STATUS_NO_RUN;
              wi_d     = '0;
              cnt_d    = lo;
              state_d  = ST_COUNT_RD;
            end else begin
              wi_d    = wi_q + AW'(1);
              bi_d    = '0;
              state_d = ST_ALLOC_RD;
            end
          end
        end else if (scan_bits == scan_mask) begin
          // all used: break the run
          run_d = '0;
          if (wi_q == LAST_WORD) begin
            status_d = STATUS_NO_RUN;
            wi_d     = '0;
            cnt_d    = lo;
            state_d  = ST_COUNT_RD;
          end else begin
            wi_d    = wi_q + AW'(1);
            bi_d    = '0;
            state_d = ST_ALLOC_RD;
          end
        end else begin
          // mixed word: step bit by bit
          wd_d    = ram_rdata;
          state_d = ST_ALLOC_BIT;
        end
      end

      ST_ALLOC_BIT: begin
        if (!wd_q[bi_q[WB-1:0]] && (run_q + LW'(1) == len_q)) begin
          ra_d    = found_start;
          rem1_d  = found_rem1;
          wi_d    = AW'(found_start >> WB);
          set_d   = 1'b1;
          start_d = SECTOR_W'(found_start);
          state_d = ST_RANGE_RD;
        end else begin
          if (!wd_q[bi_q[WB-1:0]]) begin
            run_d = run_q + LW'(1);
            if (run_q == '0) begin
              run_start_d = here_sec;
            end
          end else begin
            run_d = '0;
          end
          if (bi_q + (WB + 1)'(1) == top) begin
            if (wi_q == LAST_WORD) begin
              status_d = STATUS_NO_RUN;
              wi_d     = '0;
              cnt_d    = lo;
              state_d  = ST_COUNT_RD;
            end else begin
              wi_d    = wi_q + AW'(1);
              bi_d    = '0;
              state_d = ST_ALLOC_RD;
            end
          end else begin
            bi_d = bi_q + (WB + 1)'(1);
          end
        end
      end

      ST_RANGE_RD: begin
        ram_re  = 1'b1;
        state_d = ST_RANGE_WR;
      end

      ST_RANGE_WR: begin
        ram_we    = 1'b1;
        ram_wdata = set_q ? (ram_rdata | range_mask) : (ram_rdata & ~range_mask);
        if (wi_h == rem1_q[SW-1:WB]) begin
          wi_d    = '0;
          cnt_d   = lo;
          state_d = ST_COUNT_RD;
        end else begin
          wi_d    = wi_q + AW'(1);
          state_d = ST_RANGE_RD;
        end
      end

      ST_COUNT_RD: begin
        ram_re  = 1'b1;
        state_d = ST_COUNT_ACC;
      end

      ST_COUNT_ACC: begin
        cnt_d = cnt_q + SW'($countones(ram_rdata & count_mask));
        if (wi_q == LAST_WORD) begin
          state_d = ST_DONE;
        end else begin
          wi_d    = wi_q + AW'(1);
          state_d = ST_COUNT_RD;
        end
      end

      ST_DONE: begin
        // Hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_start_d  = start_q;
          out_used_d   = (LW'(cnt_q) > LW'(USED_LIMIT)) ? USED_LIMIT : USED_W'(cnt_q);
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      wi_q        <= '0;
      reserved_q  <= RESERVED_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wi_q        <= wi_d;
      out_valid_q <= out_valid_d;
      if (reserved_we_i) begin
        reserved_q <= reserved_sectors_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    bi_q         <= bi_d;
    run_q        <= run_d;
    run_start_q  <= run_start_d;
    len_q        <= len_d;
    ra_q         <= ra_d;
    rem1_q       <= rem1_d;
    set_q        <= set_d;
    wd_q         <= wd_d;
    cnt_q        <= cnt_d;
    status_q     <= status_d;
    start_q      <= start_d;
    out_status_q <= out_status_d;
    out_start_q  <= out_start_d;
    out_used_q   <= out_used_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign start_sector_o = out_start_q;
  assign used_sectors_o = out_used_q;

endmodule

// ----- hdl/bcsa_checker.sv -----
// Port-level checker for the bitmap contiguous sector allocator, bound to the top level.
// Depends on bcsa_pkg and bitmap_contiguous_sector_allocator_defines.svh.
`include "bitmap_contiguous_sector_allocator_defines.svh"

module bcsa_checker
  import bcsa_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  reserved_we_i,
  input logic [RESERVED_W-1:0] reserved_sectors_i,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic [KIND_W-1:0]     kind_i,
  input logic [SECTOR_W-1:0]   first_sector_i,
  input logic [LENGTH_W-1:0]   length_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [STATUS_W-1:0]   status_o,
  input logic [SECTOR_W-1:0]   start_sector_o,
  input logic [USED_W-1:0]     used_sectors_o
);

  // hold a stalled result
  `BCSA_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(status_o) && $stable(start_sector_o) && $stable(used_sectors_o))

  // a failed result carries no start sector
  `BCSA_ASSERT_IMP(a_start_on_ok, out_valid_o && (status_o != STATUS_OK), start_sector_o == '0)

  // the block goes busy after each transfer in
  `BCSA_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)

  // a new result appears only at the end of a busy period
  `BCSA_ASSERT_IMP(a_result_from_work, $rose(out_valid_o), $past(in_stall_o))

endmodule

bind bitmap_contiguous_sector_allocator bcsa_checker u_bcsa_checker (.*);

// ----- bench/bitmap_contiguous_sector_allocator_tb.sv -----
// Self-checking bench for the bitmap contiguous sector allocator: drives requests,
// predicts every result from a private copy of the free map and compares field by field.
// Depends on bcsa_pkg and the bitmap_contiguous_sector_allocator RTL.
module tb;
  import bcsa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SECTORS = 65536;

  // The fourth request code is undefined in the package; the block answers it with
  // an empty success and leaves the map alone.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [SECTOR_W-1:0] first_sector;
    logic [LENGTH_W-1:0] length;
  } sector_request_t;

  typedef struct packed {
    status_e             status;
    logic [SECTOR_W-1:0] start_sector;
    logic [USED_W-1:0]   used_sectors;
  } sector_result_t;

  // Port-side signals; every input starts at a known value.
  logic                  clk_i              = 1'b0;
  logic                  rst_ni             = 1'b0;
  logic                  reserved_we_i      = 1'b0;
  logic [RESERVED_W-1:0] reserved_sectors_i = '0;
  logic                  in_valid_i         = 1'b0;
  logic                  in_stall_o;
  logic [KIND_W-1:0]     kind_i             = '0;
  logic [SECTOR_W-1:0]   first_sector_i     = '0;
  logic [LENGTH_W-1:0]   length_i           = '0;
  logic                  out_valid_o;
  logic                  out_stall_i        = 1'b0;
  logic [STATUS_W-1:0]   status_o;
  logic [SECTOR_W-1:0]   start_sector_o;
  logic [USED_W-1:0]     used_sectors_o;

  // Private copy of the block's state: the free map (one bit per sector, set means
  // used) and the reserved bound as last written.
  bit                    sector_used [NUM_SECTORS];
  logic [RESERVED_W-1:0] reserved_cfg = RESERVED_RESET;

  sector_request_t pending_requests[$];
  sector_result_t  expected_results[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  int fail_count      = 0;
  int accepted_count  = 0;
  int ok_results      = 0;
  int no_run_results  = 0;
  int range_results   = 0;
  int bound_settings  = 1;

  always #2 clk_i = ~clk_i;

  bitmap_contiguous_sector_allocator #(
    .NUM_SECTORS (NUM_SECTORS)
  ) i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .reserved_we_i      (reserved_we_i),
    .reserved_sectors_i (reserved_sectors_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .kind_i             (kind_i),
    .first_sector_i     (first_sector_i),
    .length_i           (length_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_o           (status_o),
    .start_sector_o     (start_sector_o),
    .used_sectors_o     (used_sectors_o)
  );

  // Apply one accepted request to the private map and return what the block must
  // answer. A bound above the store size acts as the store size.
  function automatic sector_result_t apply_request(sector_request_t req);
    sector_result_t res;
    int unsigned    lo, sec, run, run_start, stop, total;
    bit             found;
    lo        = (reserved_cfg > NUM_SECTORS) ? NUM_SECTORS : reserved_cfg;
    res       = '{status: STATUS_OK, start_sector: '0, used_sectors: '0};
    found     = 1'b0;
    run       = 0;
    run_start = 0;
    case (req.kind)
      KIND_ALLOC: begin
        // Empty allocation claims nothing and still succeeds.
        if (req.length != '0) begin
          // First fit: the lowest run of free sectors at or above the bound.
          for (sec = lo; sec < NUM_SECTORS && !found; sec++) begin
            if (sector_used[sec]) begin
              run = 0;
            end else begin
              if (run == 0) run_start = sec;
              run++;
              found = (run == req.length);
            end
          end
          if (found) begin
            for (sec = run_start; sec < run_start + req.length; sec++) sector_used[sec] = 1'b1;
            res.start_sector = SECTOR_W'(run_start);
          end else begin
            res.status = STATUS_NO_RUN;
          end
        end
      end
      KIND_RELEASE, KIND_MARK: begin
        stop = req.first_sector + req.length;
        if (stop > NUM_SECTORS) begin
          res.status = STATUS_RANGE;
        end else begin
          // Skip whatever part of the range lies in the reserved region.
          for (sec = (req.first_sector < lo) ? lo : req.first_sector; sec < stop; sec++)
            sector_used[sec] = (req.kind == KIND_MARK);
        end
      end
      default: ;
    endcase
    // Reserved sectors always count as used; bits left below a raised bound are not
    // counted a second time.
    total = lo;
    for (sec = lo; sec < NUM_SECTORS; sec++) total += sector_used[sec];
    res.used_sectors = (total > USED_LIMIT) ? USED_LIMIT : USED_W'(total);
    return res;
  endfunction

  // Request driver: record the transfer that completes at this edge, then present
  // the next pending request unless the sender chooses to idle. Hold a stalled
  // payload untouched.
  always @(posedge clk_i) begin : request_driver
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(apply_request({kind_i, first_sector_i, length_i}));
        accepted_count++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          {kind_i, first_sector_i, length_i} <= pending_requests.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare every completed result transfer against the oldest
  // expectation, then pick the stall for the next cycle.
  always @(posedge clk_i) begin : result_monitor
    sector_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        case (status_o)
          STATUS_OK:     ok_results++;
          STATUS_NO_RUN: no_run_results++;
          default:       range_results++;
        endcase
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: status %0d start_sector %0d used_sectors %0d",
                 status_o, start_sector_o, used_sectors_o);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status_o);
            fail_count++;
          end
          if (start_sector_o !== want.start_sector) begin
            $error("start_sector: expected %0d, actual %0d", want.start_sector, start_sector_o);
            fail_count++;
          end
          if (used_sectors_o !== want.used_sectors) begin
            $error("used_sectors: expected %0d, actual %0d", want.used_sectors, used_sectors_o);
            fail_count++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic void queue_request(input logic [KIND_W-1:0]   req_kind,
                                        input logic [SECTOR_W-1:0] req_first,
                                        input logic [LENGTH_W-1:0] req_length);
    pending_requests.push_back('{kind: req_kind, first_sector: req_first, length: req_length});
  endfunction

  // Queue random traffic around the current bound: mostly short allocations and
  // small releases and marks where the allocations land, plus the unused code,
  // unbounded ranges and now and then a release of the whole store.
  task automatic queue_random(input int count);
    sector_request_t req;
    int unsigned     base, pick;
    base = (reserved_cfg > NUM_SECTORS) ? NUM_SECTORS : reserved_cfg;
    for (int n = 0; n < count; n++) begin
      pick             = $urandom_range(99);
      req.kind         = KIND_ALLOC;
      req.first_sector = SECTOR_W'($urandom());
      req.length       = LENGTH_W'($urandom_range(48, 1));
      if (pick < 45) begin
        if ($urandom_range(9) == 0) req.length = LENGTH_W'($urandom_range(4096, 49));
        else if ($urandom_range(19) == 0) req.length = '0;
      end else if (pick < 72) begin
        req.kind         = KIND_RELEASE;
        req.first_sector = SECTOR_W'(base + $urandom_range(3071));
        req.length       = LENGTH_W'($urandom_range(96, 0));
      end else if (pick < 86) begin
        req.kind         = KIND_MARK;
        req.first_sector = SECTOR_W'(base + $urandom_range(4095));
        req.length       = LENGTH_W'($urandom_range(24, 0));
      end else if (pick < 90) begin
        req.kind   = KIND_UNUSED;
        req.length = LENGTH_W'($urandom());
      end else if (pick < 96) begin
        req.kind   = KIND_W'($urandom_range(2));
        req.length = LENGTH_W'($urandom());
      end else begin
        req.kind         = KIND_RELEASE;
        req.first_sector = '0;
        req.length       = LENGTH_W'(NUM_SECTORS);
      end
      pending_requests.push_back(req);
    end
  endtask

  // Wait until nothing is queued, presented or outstanding. Sample at the falling
  // edge so the driver's updates at the rising edge have settled.
  task automatic drain();
    while (pending_requests.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Write the reserved bound while the block is idle and mirror it privately.
  task automatic set_reserved(input logic [RESERVED_W-1:0] value);
    @(posedge clk_i);
    reserved_we_i      <= 1'b1;
    reserved_sectors_i <= value;
    reserved_cfg        = value;
    @(posedge clk_i);
    reserved_we_i <= 1'b0;
    bound_settings++;
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed pass at the reset bound of 128, no idling on either side.
    queue_request(KIND_ALLOC,   '0,     '0);        // empty allocation
    queue_request(KIND_ALLOC,   '0,     17'd1);
    queue_request(KIND_ALLOC,   '0,     17'd100);
    queue_request(KIND_MARK,    16'hFFFF, 17'd1);   // last sector of the store
    queue_request(KIND_MARK,    16'hFFFF, 17'd2);   // one past the end
    queue_request(KIND_RELEASE, 16'd1,  17'd65536);
    queue_request(KIND_RELEASE, 16'hFFFF, 17'h1FFFF);
    queue_request(KIND_RELEASE, '0,     17'd65536); // whole store, reserved part skipped
    queue_request(KIND_ALLOC,   '0,     17'd65536); // longer than any free run
    queue_request(KIND_ALLOC,   '0,     17'h1FFFF);
    queue_request(KIND_ALLOC,   '0,     17'd65408); // exactly everything above the bound
    queue_request(KIND_ALLOC,   '0,     17'd1);     // store full
    queue_request(KIND_RELEASE, 16'd200, 17'd50);
    queue_request(KIND_ALLOC,   '0,     17'd51);    // hole one sector too short
    queue_request(KIND_ALLOC,   '0,     17'd50);
    queue_request(KIND_RELEASE, 16'd64, 17'd128);   // straddles the reserved bound
    queue_request(KIND_MARK,    '0,     '0);        // empty range
    queue_request(KIND_RELEASE, 16'hFFFF, '0);
    queue_request(KIND_UNUSED,  16'hFFFF, 17'h1FFFF);
    queue_request(KIND_ALLOC,   16'hFFFF, 17'd64);  // start field ignored by allocate
    queue_request(KIND_MARK,    '0,     17'd1);     // entirely reserved
    queue_request(KIND_RELEASE, '0,     17'd65536);
    drain();

    // No reserved region, sender mostly idle; end with a marked block that the
    // next bound will partly cover.
    set_reserved('0);
    send_idle_pct = 83;
    queue_request(KIND_ALLOC,   '0, 17'd65536);     // whole store from sector zero
    queue_request(KIND_RELEASE, '0, 17'd65536);
    queue_request(KIND_ALLOC,   '0, 17'd3);
    queue_random(45);
    queue_request(KIND_RELEASE, '0, 17'd65536);
    queue_request(KIND_MARK,    16'd500, 17'd300);
    drain();

    // Raise the bound over part of the marked block; receiver mostly stalling.
    set_reserved(17'd600);
    send_idle_pct  = 0;
    recv_stall_pct = 83;
    queue_request(KIND_ALLOC,   '0, 17'd1);
    queue_request(KIND_RELEASE, '0, 17'd1000);
    queue_random(50);
    drain();

    // Bound at the store size: nothing is ever allocatable.
    set_reserved(17'd65536);
    send_idle_pct  = 18;
    recv_stall_pct = 18;
    queue_request(KIND_ALLOC,   '0, 17'd1);
    queue_request(KIND_MARK,    16'hFFFF, 17'd1);
    queue_request(KIND_RELEASE, '0, 17'd65536);
    queue_request(KIND_ALLOC,   '0, '0);
    queue_random(20);
    drain();

    // Bound beyond the store, every register bit set; no idling.
    set_reserved(17'h1FFFF);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    queue_request(KIND_ALLOC, '0, 17'd1);
    queue_random(10);
    drain();

    // Random bound, both sides idling a little; hold the sender midway until every
    // outstanding result has come back.
    set_reserved(RESERVED_W'($urandom_range(4096)));
    send_idle_pct  = 18;
    recv_stall_pct = 18;
    queue_random(30);
    drain();
    queue_random(30);
    drain();

    // Back to the reset bound, sender mostly idle.
    set_reserved(RESERVED_RESET);
    send_idle_pct  = 83;
    recv_stall_pct = 0;
    queue_random(70);
    drain();

    repeat (50) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      fail_count++;
    end
    $display("Covered %0d requests under %0d reserved-bound settings: %0d ok, %0d refused",
             accepted_count, bound_settings, ok_results, no_run_results);
    $display("for want of a free run, %0d rejected as outside the store.", range_results);
    if (fail_count == 0) begin
      $display("bitmap_contiguous_sector_allocator verification clean");
    end else begin
      $display("bitmap_contiguous_sector_allocator verification failed");
    end
    $finish;
  end

  // Drop the run if it hangs; the bound sits well above the slowest legal run.
  initial begin : watchdog
    #400_000_000;
    $display("bitmap_contiguous_sector_allocator verification failed");
    $finish;
  end

endmodule
